FILE: rtl/key_matrix_note_priority_cv_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key matrix note priority block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_NOTE_PRIORITY_CV_MACROS_SVH
`define KEY_MATRIX_NOTE_PRIORITY_CV_MACROS_SVH

// Same-cycle implication.
`define KNPC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("knpc assertion failed");

// Next-cycle implication.
`define KNPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("knpc assertion failed");

`endif

FILE: rtl/knpc_pkg.sv
// ----------------------------------------------------------------------------
// knpc_pkg
// Types and constants of the key matrix note priority block.
// ----------------------------------------------------------------------------
package knpc_pkg;

    localparam int ROW_COUNT    = 11;
    localparam int COLUMN_COUNT = 6;
    localparam int KEY_COUNT    = 61;
    localparam int DAC_BITS     = 12;
    localparam int BASS_KEYS    = 25;
    localparam int KEY_BITS     = 6;
    localparam int COLUMN_BITS  = 3;

    // The DAC scale (2^12 - 1) / 60 equals 273 / 4 exactly.
    localparam int DAC_NUM   = 273;
    localparam int DAC_SHIFT = 2;
    localparam int PROD_BITS = 15;

    typedef logic [KEY_COUNT-1:0] key_map_t;

    typedef struct packed {
        logic [COLUMN_BITS-1:0] column;
        logic [ROW_COUNT-1:0]   row_bits;
        logic                   end_of_scan;
    } item_t;

    typedef struct packed {
        logic                 any_key_down;
        logic [KEY_BITS-1:0]  lowest_key;
        logic [KEY_BITS-1:0]  highest_key;
        logic [DAC_BITS-1:0]  cv_upper;
        logic [DAC_BITS-1:0]  cv_lower;
        logic [BASS_KEYS-1:0] bass_gates;
    } result_t;

    typedef struct packed {
        logic                   enable;
        logic [COLUMN_BITS-1:0] column;
        logic [ROW_COUNT-1:0]   row_bits;
    } map_update_t;

    function automatic logic [DAC_BITS-1:0] dac_code(input logic [KEY_BITS-1:0] key);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(key) * PROD_BITS'(DAC_NUM);
        return DAC_BITS'(prod >> DAC_SHIFT);
    endfunction

endpackage

FILE: rtl/knpc_key_map.sv
// ----------------------------------------------------------------------------
// knpc_key_map
// Holds the pressed-key map and applies one scanned column to it.
// ----------------------------------------------------------------------------
module knpc_key_map (
    input  logic                 clk,
    input  logic                 rst_n,
    input  knpc_pkg::map_update_t update,
    output knpc_pkg::key_map_t   map_next
);

    import knpc_pkg::*;

    key_map_t   key_map_reg;
    logic [2:0] offset;
    logic [6:0] base;
    logic [6:0] key;

    always_comb
    begin
        map_next = key_map_reg;
        offset   = (update.column == '0) ? COLUMN_BITS'(COLUMN_COUNT) : update.column;
        base     = '0;
        key      = '0;
        if (update.enable && (32'(update.column) < COLUMN_COUNT))
        begin
            for (int o = 0; o < ROW_COUNT; o++)
            begin
                base = 7'(offset) + 7'(COLUMN_COUNT * o);
                key  = base - 7'(COLUMN_COUNT);
                if ((base >= 7'(COLUMN_COUNT)) && (key < 7'(KEY_COUNT)))
                begin
                    map_next[key[KEY_BITS-1:0]] = update.row_bits[o];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_map_reg <= '0;
        end
        else
        begin
            key_map_reg <= map_next;
        end
    end

endmodule

FILE: rtl/knpc_priority.sv
// ----------------------------------------------------------------------------
// knpc_priority
// Finds the lowest and highest pressed key, forms the DAC codes and passes the bass key gates.
// ----------------------------------------------------------------------------
module knpc_priority (
    input  knpc_pkg::key_map_t key_map,
    output knpc_pkg::result_t  result
);

    import knpc_pkg::*;

    logic [KEY_BITS-1:0] lo;
    logic [KEY_BITS-1:0] hi;
    logic                found;

    always_comb
    begin
        lo = '0;
        hi = '0;
        for (int n = KEY_COUNT - 1; n >= 0; n--)
        begin
            if (key_map[n])
            begin
                lo = KEY_BITS'(n);
            end
        end
        for (int n = 0; n < KEY_COUNT; n++)
        begin
            if (key_map[n])
            begin
                hi = KEY_BITS'(n);
            end
        end
    end

    assign found = |key_map;

    always_comb
    begin
        result.any_key_down = found;
        result.lowest_key   = found ? lo : '0;
        result.highest_key  = found ? hi : '0;
        result.cv_upper     = found ? dac_code(hi) : '0;
        result.cv_lower     = found ? dac_code(lo) : '0;
        result.bass_gates   = key_map[BASS_KEYS-1:0];
    end

endmodule

FILE: rtl/key_matrix_note_priority_cv.sv
// ----------------------------------------------------------------------------
// key_matrix_note_priority_cv
// Key matrix scanner with lowest and highest note priority and CV codes.
// ----------------------------------------------------------------------------
// One column transaction is taken every clock cycle while the input side
// does not stall. An accepted transaction is held in the input register,
// from which it updates the 61-key map as it leaves; on an end-of-scan
// transaction the priority encoders and DAC scaling load the result register
// from the updated map, and the result is offered from then on.
// The input side stalls only when an end-of-scan transaction meets a result
// that has not yet been taken.
module key_matrix_note_priority_cv (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  knpc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output knpc_pkg::result_t result
);

    import knpc_pkg::*;

    item_t       s1_item_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        advance;
    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    result_t     result_calc;
    key_map_t    map_next;
    map_update_t update;

    assign advance = s1_valid_reg
                   && (!s1_item_reg.end_of_scan || !result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;

    assign update.enable   = advance;
    assign update.column   = s1_item_reg.column;
    assign update.row_bits = s1_item_reg.row_bits;

    knpc_key_map u_key_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (update),
        .map_next (map_next)
    );

    knpc_priority u_priority (
        .key_map (map_next),
        .result  (result_calc)
    );

    always_comb
    begin
        s1_valid_next = item_ready ? item_valid : s1_valid_reg;
        if (advance && s1_item_reg.end_of_scan)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
        if (advance && s1_item_reg.end_of_scan)
        begin
            result_reg <= result_calc;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/knpc_checker.sv
// ----------------------------------------------------------------------------
// knpc_checker
// Port-level checks of the key matrix note priority block.
// ----------------------------------------------------------------------------
`include "key_matrix_note_priority_cv_macros.svh"

module knpc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input knpc_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_ready,
    input knpc_pkg::result_t result
);

    import knpc_pkg::*;

    logic notes_clear;
    logic keys_ordered;
    logic codes_match;

    assign notes_clear  = (result.lowest_key == '0) && (result.highest_key == '0)
                       && (result.cv_upper == '0) && (result.cv_lower == '0)
                       && (result.bass_gates == '0);
    assign keys_ordered = (result.lowest_key <= result.highest_key)
                       && (32'(result.highest_key) < KEY_COUNT);
    assign codes_match  = (result.cv_upper == dac_code(result.highest_key))
                       && (result.cv_lower == dac_code(result.lowest_key));

    `KNPC_ASSERT_NEXT(a_item_held, item_valid && !item_ready, item_valid && $stable(item))
    `KNPC_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result))
    `KNPC_ASSERT_IMPLY(a_idle_zero, result_valid && !result.any_key_down, notes_clear)
    `KNPC_ASSERT_IMPLY(a_key_order, result_valid && result.any_key_down, keys_ordered)
    `KNPC_ASSERT_IMPLY(a_cv_match, result_valid, codes_match)

endmodule

bind key_matrix_note_priority_cv knpc_checker u_knpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
